FILE: hw/rtl/lsct_pkg.sv
// Shared types and constants for the line sensor threshold calibration block.
package lsct_pkg;

    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 12;
    localparam int PAT_W    = 16;
    localparam int REQ_W    = 2;
    localparam int PRESET_DEPTH = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLASSIFY = 2'd0,
        REQ_CAL      = 2'd1,
        REQ_RESTART  = 2'd2,
        REQ_UNUSED   = 2'd3
    } req_t;

    // One channel's calibration entry.
    typedef struct packed {
        logic [SAMPLE_W-1:0] min_v;
        logic [SAMPLE_W-1:0] max_v;
        logic [SAMPLE_W-1:0] thr_v;
    } entry_t;

    typedef logic [SAMPLE_W-1:0] preset_tab_t [PRESET_DEPTH];

    localparam preset_tab_t PRESET_TAB = '{
        12'd2163, 12'd2279, 12'd2460, 12'd2460, 12'd2580, 12'd2668, 12'd2607, 12'd2567,
        12'd2574, 12'd2696, 12'd2585, 12'd2464, 12'd2382, 12'd2423, 12'd2414, 12'd2249
    };

    function automatic logic [SAMPLE_W-1:0] preset_thr(input logic [CH_W-1:0] idx);
        return PRESET_TAB[idx];
    endfunction

endpackage

FILE: hw/rtl/lsct_chan_mem.sv
// Per-channel min/max/threshold memories with entry valid bits and restart handling.
module lsct_chan_mem #(
    parameter int NUM_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rd_en,
    input  logic [lsct_pkg::CH_W-1:0]   rd_addr,
    output lsct_pkg::entry_t            rd_data,
    input  logic                        wr_en,
    input  logic [lsct_pkg::CH_W-1:0]   wr_addr,
    input  lsct_pkg::entry_t            wr_data,
    input  logic                        restart
);
    import lsct_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] MASK = SAMPLE_W'((1 << DW) - 1);
    localparam logic [SAMPLE_W-1:0] HALF = MASK >> 1;

    logic [DW-1:0] min_mem [NUM_CHANNELS];
    logic [DW-1:0] max_mem [NUM_CHANNELS];
    logic [DW-1:0] thr_mem [NUM_CHANNELS];

    logic [DW-1:0] min_q;
    logic [DW-1:0] max_q;
    logic [DW-1:0] thr_q;

    logic [NUM_CHANNELS-1:0] valid_reg;
    logic                    restarted_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic                    hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            min_mem[wr_addr[AW-1:0]] <= wr_data.min_v[DW-1:0];
            max_mem[wr_addr[AW-1:0]] <= wr_data.max_v[DW-1:0];
            thr_mem[wr_addr[AW-1:0]] <= wr_data.thr_v[DW-1:0];
        end
        if (rd_en)
        begin
            min_q <= min_mem[rd_addr[AW-1:0]];
            max_q <= max_mem[rd_addr[AW-1:0]];
            thr_q <= thr_mem[rd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            restarted_reg <= 1'b0;
            rd_addr_reg   <= '0;
        end
        else
        begin
            // drop every entry on restart; unwritten entries read their defaults
            if (restart)
            begin
                valid_reg     <= '0;
                restarted_reg <= 1'b1;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr[AW-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_addr_reg <= rd_addr[AW-1:0];
            end
        end
    end

    assign hit = valid_reg[rd_addr_reg];

    always_comb
    begin
        if (hit)
        begin
            rd_data.min_v = SAMPLE_W'(min_q);
            rd_data.max_v = SAMPLE_W'(max_q);
            rd_data.thr_v = SAMPLE_W'(thr_q);
        end
        else
        begin
            rd_data.min_v = MASK;
            rd_data.max_v = '0;
            rd_data.thr_v = restarted_reg ? HALF : (preset_thr(CH_W'(rd_addr_reg)) & MASK);
        end
    end

endmodule

FILE: hw/rtl/line_sensor_calibrate_threshold_core.sv
// Top level of the line sensor threshold calibration block.
//
//  channel  | dir | tdata (low bit up)                                  | side bits
//  s_*      | in  | channel[3:0], sample[15:4]                          | tuser: req_type
//  m_*      | out | channel_echo, is_white, line_pattern, threshold_now | tlast: sweep_done
//
// One item per cycle sustained while m_tready keeps the output moving; an accepted item
// passes the compute stage register and then the output register before m_tvalid rises.
// The channel entry is read from the synchronous memories at accept and written back
// when the compute stage advances; a write that meets a read of the same channel is forwarded.
// Reset clears valid bits, the pattern and the pipeline; memories need no clearing pass.
// A stall on m_tready holds the compute stage and lowers s_tready only when both
// the compute stage and the output register are full.
module line_sensor_calibrate_threshold_core #(
    parameter int NUM_CHANNELS = 16,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // channel[3:0], sample[15:4]
    input  logic [lsct_pkg::REQ_W-1:0]    s_tuser,   // req_type[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // channel_echo[3:0], is_white[4],
                                                     // line_pattern[20:5],
                                                     // threshold_now[32:21], zero[39:33]
    output logic                          m_tlast    // sweep_done
);
    import lsct_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_W-1:0] MASK = SAMPLE_W'((1 << DW) - 1);
    localparam logic [SAMPLE_W-1:0] HALF = MASK >> 1;

    logic [CH_W-1:0]     in_ch;
    logic [SAMPLE_W-1:0] in_sample;
    logic                in_ch_ok;
    logic                accept;

    // compute stage
    logic                s1_valid_reg;
    req_t                s1_req_reg;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_ok_reg;
    logic                s1_adv;

    // forwarding of a write that lands on the same edge as the read
    logic                fwd_hit_reg;
    entry_t              fwd_reg;

    entry_t              mem_rd;
    entry_t              ent;
    entry_t              wr_ent;
    logic                wr_en;
    logic                restart;

    logic [NUM_CHANNELS-1:0] pattern_reg;
    logic [NUM_CHANNELS-1:0] pattern_next;

    logic                white;
    logic [SAMPLE_W-1:0] new_min;
    logic [SAMPLE_W-1:0] new_max;
    logic [SAMPLE_W:0]   mid_sum;
    logic [SAMPLE_W-1:0] thr_out;
    logic                done;

    logic                out_valid_reg;
    logic [CH_W-1:0]     out_ch_reg;
    logic                out_white_reg;
    logic [PAT_W-1:0]    out_pat_reg;
    logic [SAMPLE_W-1:0] out_thr_reg;
    logic                out_done_reg;

    assign in_ch     = s_tdata[CH_W-1:0];
    assign in_sample = s_tdata[15:CH_W] & MASK;
    assign in_ch_ok  = ({1'b0, in_ch} < (CH_W+1)'(NUM_CHANNELS));

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    lsct_chan_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_ch_ok),
        .rd_addr (in_ch),
        .rd_data (mem_rd),
        .wr_en   (wr_en),
        .wr_addr (s1_ch_reg),
        .wr_data (wr_ent),
        .restart (restart)
    );

    assign ent = fwd_hit_reg ? fwd_reg : mem_rd;

    always_comb
    begin
        white        = (s1_sample_reg > ent.thr_v);
        new_min      = (s1_sample_reg < ent.min_v) ? s1_sample_reg : ent.min_v;
        new_max      = (s1_sample_reg > ent.max_v) ? s1_sample_reg : ent.max_v;
        mid_sum      = {1'b0, new_min} + {1'b0, new_max};
        wr_ent.min_v = new_min;
        wr_ent.max_v = new_max;
        wr_ent.thr_v = mid_sum[SAMPLE_W:1] & MASK;

        wr_en   = s1_adv && s1_ok_reg && (s1_req_reg == REQ_CAL);
        restart = s1_adv && (s1_req_reg == REQ_RESTART);

        pattern_next = pattern_reg;
        done         = 1'b0;
        thr_out      = '0;
        case (s1_req_reg)
            REQ_CLASSIFY:
            begin
                if (s1_ok_reg)
                begin
                    pattern_next[s1_ch_reg[AW-1:0]] = white;
                    done    = (s1_ch_reg == CH_W'(NUM_CHANNELS - 1));
                    thr_out = ent.thr_v;
                end
            end
            REQ_CAL:
            begin
                if (s1_ok_reg)
                begin
                    thr_out = wr_ent.thr_v;
                end
            end
            REQ_RESTART:
            begin
                thr_out = s1_ok_reg ? HALF : '0;
            end
            default:
            begin
                if (s1_ok_reg)
                begin
                    thr_out = ent.thr_v;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pattern_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= wr_en && (s1_ch_reg == in_ch);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                pattern_reg   <= pattern_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg    <= req_t'(s_tuser);
            s1_ch_reg     <= in_ch;
            s1_sample_reg <= in_sample;
            s1_ok_reg     <= in_ch_ok;
        end
        if (wr_en)
        begin
            fwd_reg <= wr_ent;
        end
        if (s1_adv)
        begin
            out_ch_reg    <= s1_ch_reg;
            out_white_reg <= s1_ok_reg && (s1_req_reg == REQ_CLASSIFY) && white;
            out_pat_reg   <= PAT_W'(pattern_next);
            out_thr_reg   <= thr_out;
            out_done_reg  <= done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {7'd0, out_thr_reg, out_pat_reg, out_white_reg, out_ch_reg};

    a_fwd_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fwd_hit_reg) |-> $past(wr_en))
        else $error("forward flag set without a write on the read edge");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_ch_reg)))
        else $error("compute stage lost its item while stalled");

    a_sweep_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[CH_W-1:0] == CH_W'(NUM_CHANNELS - 1)))
        else $error("sweep_done on a channel other than the last");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (s1_ok_reg && !restart))
        else $error("memory write for an out-of-range channel or during restart");

endmodule
